>>> rtl/core/ppd_pkg.sv
// Shared widths, mode codes and defaults of the proportional pool distributor.
// Depends on nothing; imported by the distributor top level and its divider.
`timescale 1ns / 1ps

package ppd_pkg;

   localparam int WEIGHT_W        = 16;
   localparam int POOL_W          = 31;
   localparam int MODE_W          = 2;
   localparam int VALUE_W         = 32;
   localparam int ENTRY_W         = 6;
   localparam int MAX_ENTRIES_DEF = 64;

   // Widest dividend is a weight times the magnitude of the pool.
   localparam int DIVIDEND_W = WEIGHT_W + POOL_W;

   localparam logic [MODE_W-1:0] MODE_EVEN     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STRICT   = 2'd2;

endpackage

>>> rtl/core/ppd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ppd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ppd_divider.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
// Depends on ppd_pkg for its default dividend width.
`timescale 1ns / 1ps

module ppd_divider
   import ppd_pkg::*;
#(
   parameter int DVD_W = DIVIDEND_W,
   parameter int DVS_W = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(DVD_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/proportional_pool_distributor.sv
// Proportional pool distributor: loads weights, then splits a signed pool over them.
// A load item is taken and the block stays ready; the last item starts a walk.
// Each entry of the walk goes through read, setup, a divider step per quotient bit and emit,
// paced by the one-bit-per-cycle shared divider; an entry with no division emits from setup.
// Busy stays high for the whole walk; results are never stalled.
// Synchronous active-high reset clears the sequencer, counters and sums, but not the store.
`timescale 1ns / 1ps

module proportional_pool_distributor
   import ppd_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [WEIGHT_W-1:0]       req_weight,
   input  logic signed [POOL_W-1:0]  req_pool_amount,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic                      req_is_last,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_new_value,
   output logic [ENTRY_W-1:0]        rsp_entry_index,
   output logic                      rsp_last_result
);

   // Index into the store, count of stored entries (which can equal the depth),
   // and the weight sum, which must hold MAX_ENTRIES full-scale weights.
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W = WEIGHT_W + CNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SETUP,
      S_DIVIDE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SUM_W-1:0]          total_ff, total_in;
   logic [SUM_W-1:0]          rem_sum_ff, rem_sum_in;
   logic signed [VALUE_W-1:0] pool_ff, pool_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      even_ff, even_in;
   logic [WEIGHT_W-1:0]       wt_ff, wt_in;
   logic                      strobe_ff, strobe_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [ENTRY_W-1:0]        entry_ff, entry_in;
   logic                      lastr_ff, lastr_in;

   logic                      accept;
   logic                      store;
   logic [CNT_W-1:0]          next_count;
   logic [SUM_W-1:0]          next_total;
   logic [WEIGHT_W-1:0]       rd_weight;
   logic [VALUE_W-1:0]        pool_mag;
   logic                      last_entry;
   logic [ENTRY_W+IDX_W-1:0]  idx_ext;
   logic                      div_start;
   logic [DIVIDEND_W-1:0]     div_dividend;
   logic [SUM_W-1:0]          div_divisor;
   logic                      div_done;
   logic [DIVIDEND_W-1:0]     div_quotient;
   logic                      emit_go;
   logic                      emit_skip;
   logic [WEIGHT_W-1:0]       emit_wt;
   logic signed [VALUE_W-1:0] portion;

   // An item is taken only while the sequencer idles; a list longer than the
   // store simply drops the extra weights, the last one included.
   assign accept     = start && (state_ff == S_IDLE);
   assign store      = accept && (count_ff < CNT_W'(MAX_ENTRIES));
   assign next_count = store ? count_ff + CNT_W'(1) : count_ff;
   assign next_total = store ? total_ff + SUM_W'(req_weight) : total_ff;

   assign busy = (state_ff != S_IDLE);

   // The walk always covers the stored entries; the final one carries the flag.
   assign last_entry = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign idx_ext    = {{ENTRY_W{1'b0}}, idx_ff};

   // The divider works on magnitudes; the quotient takes the pool's sign back,
   // which gives truncation toward zero. The remaining pool never exceeds the
   // initial magnitude, so its low POOL_W bits carry the whole magnitude.
   assign pool_mag = pool_ff[VALUE_W-1] ? VALUE_W'(-pool_ff) : VALUE_W'(pool_ff);

   ppd_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_weight),
      .rd_addr (idx_ff),
      .rd_data (rd_weight)
   );

   ppd_divider #(
      .DVD_W (DIVIDEND_W),
      .DVS_W (SUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Operands for the shared divider. Even mode divides the pool by the number
   // of entries still to go; weighted mode divides weight times pool by the
   // weight left in the sum. The product lands in the divider's input register.
   always_comb begin
      if (even_ff) begin
         div_dividend = DIVIDEND_W'(pool_mag[POOL_W-1:0]);
         div_divisor  = SUM_W'(count_ff - CNT_W'(idx_ff));
      end else begin
         div_dividend = DIVIDEND_W'(rd_weight * pool_mag[POOL_W-1:0]);
         div_divisor  = rem_sum_ff;
      end
   end

   // Sequencer. A result is emitted either when the divider reports done, or
   // straight from setup when a weighted walk has used up its weight sum; the
   // remaining entries then all have zero weight and pass through unchanged.
   always_comb begin
      state_in   = state_ff;
      count_in   = next_count;
      total_in   = next_total;
      rem_sum_in = rem_sum_ff;
      pool_in    = pool_ff;
      idx_in     = idx_ff;
      even_in    = even_ff;
      wt_in      = wt_ff;
      strobe_in  = 1'b0;
      value_in   = value_ff;
      entry_in   = entry_ff;
      lastr_in   = lastr_ff;
      div_start  = 1'b0;
      emit_go    = 1'b0;
      emit_skip  = 1'b0;
      emit_wt    = wt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_is_last) begin
               // Mode 3 behaves like strict weighted mode.
               rem_sum_in = next_total;
               pool_in    = VALUE_W'(req_pool_amount);
               idx_in     = '0;
               even_in    = (req_mode == MODE_EVEN) ||
                            ((req_mode == MODE_WEIGHTED) && (next_total == '0));
               state_in   = S_READ;
            end
         end
         S_READ: begin
            state_in = S_SETUP;
         end
         S_SETUP: begin
            wt_in = rd_weight;
            if (even_ff || (rem_sum_ff != '0)) begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end else begin
               emit_go   = 1'b1;
               emit_skip = 1'b1;
               emit_wt   = rd_weight;
            end
         end
         S_DIVIDE: begin
            emit_go = div_done;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_skip) begin
         portion = '0;
      end else if (pool_ff[VALUE_W-1]) begin
         portion = -$signed(div_quotient[VALUE_W-1:0]);
      end else begin
         portion = $signed(div_quotient[VALUE_W-1:0]);
      end

      if (emit_go) begin
         strobe_in = 1'b1;
         value_in  = $signed({{(VALUE_W-WEIGHT_W){1'b0}}, emit_wt}) + portion;
         entry_in  = idx_ext[ENTRY_W-1:0];
         lastr_in  = last_entry;
         pool_in   = pool_ff - portion;
         if (!even_ff && !emit_skip) begin
            rem_sum_in = rem_sum_ff - SUM_W'(emit_wt);
         end
         if (last_entry) begin
            count_in = '0;
            total_in = '0;
            idx_in   = '0;
            state_in = S_IDLE;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            state_in = S_READ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         total_ff   <= '0;
         rem_sum_ff <= '0;
         pool_ff    <= '0;
         idx_ff     <= '0;
         even_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
         rem_sum_ff <= rem_sum_in;
         pool_ff    <= pool_in;
         idx_ff     <= idx_in;
         even_ff    <= even_in;
         strobe_ff  <= strobe_in;
      end
      wt_ff    <= wt_in;
      value_ff <= value_in;
      entry_ff <= entry_in;
      lastr_ff <= lastr_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_new_value   = value_ff;
   assign rsp_entry_index = entry_ff;
   assign rsp_last_result = lastr_ff;

endmodule

>>> rtl/core/ppd_checker.sv
// Port-level checks on the distributor's walk sequencing, and their bind.
// Depends on the proportional_pool_distributor top level.
`timescale 1ns / 1ps

module ppd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_result
);

   // Every entry passes through a read and a setup state.
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on adjacent cycles");

   // The final result of a walk returns the block to ready.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_result |-> !busy)
      else $error("busy after the final result");

   // Any other result belongs to a walk that is still running.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |-> busy)
      else $error("walk ended before its final result");

   // A walk only starts from an accepted item.
   a_rise_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an item");

endmodule

bind proportional_pool_distributor ppd_checker u_ppd_checker (.*);

>>> bench/tb_proportional_pool_distributor.sv
`timescale 1ns / 1ps
// Self-checking bench for proportional_pool_distributor: a short table of directed lists,
// then random weight lists, each entry checked against an in-bench model of the pool split or a typed result.
// Depends on ppd_pkg for widths and mode codes, and on the distributor RTL itself.

module tb_proportional_pool_distributor;
   import ppd_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int ITEM_TARGET  = 260;
   // A walk emits its entries steadily while busy, so STALL_LIMIT quiet cycles mean a hang.
   localparam int STALL_LIMIT  = 5000;
   // Time left after the last expected entry for any stray result to show up.
   localparam int DRAIN_CYCLES = 150;

   // Mode 3 has no name in the package; the block treats it as weighted strict.
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   localparam logic signed [POOL_W-1:0] POOL_MAX = {1'b0, {(POOL_W-1){1'b1}}};
   localparam logic signed [POOL_W-1:0] POOL_MIN = {1'b1, {(POOL_W-1){1'b0}}};

   // One load item as it goes onto the request ports. A row marked typed carries the single
   // result of a one-entry list written out by hand; other rows rely on the model below.
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [POOL_W-1:0]   pool_amount;
      logic [MODE_W-1:0]   mode;
      logic                is_last;
      logic                typed;
      logic [VALUE_W-1:0]  typed_value;
   } load_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] new_value;
      logic [ENTRY_W-1:0] entry_index;
      logic               last_result;
   } entry_result_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [WEIGHT_W-1:0]       req_weight;
   logic signed [POOL_W-1:0]  req_pool_amount;
   logic [MODE_W-1:0]         req_mode;
   logic                      req_is_last;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_new_value;
   logic [ENTRY_W-1:0]        rsp_entry_index;
   logic                      rsp_last_result;

   load_item_type    load_items[$];
   entry_result_type pending_results[$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;

   // Model state: the weights of the list being loaded and what the last walk left over.
   logic [WEIGHT_W-1:0] list_weights [MAX_ENTRIES_DEF];
   int unsigned         list_len = 0;
   longint              unsplit_sum = 0;
   longint              unsplit_pool = 0;

   proportional_pool_distributor i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_weight      (req_weight),
      .req_pool_amount (req_pool_amount),
      .req_mode        (req_mode),
      .req_is_last     (req_is_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_new_value   (rsp_new_value),
      .rsp_entry_index (rsp_entry_index),
      .rsp_last_result (rsp_last_result)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stores one weight and, on the last item of a list, walks the list and queues one expected
   // entry per stored weight. Weights past the store's capacity are dropped, the last one too.
   task automatic split_pool(input load_item_type it);
      longint           total;
      longint           wt;
      longint           portion;
      logic             even_split;
      entry_result_type res;
      if (list_len < MAX_ENTRIES_DEF) begin
         list_weights[list_len] = it.weight;
         list_len++;
      end
      if (it.is_last) begin
         total = 0;
         for (int i = 0; i < list_len; i++) begin
            total += longint'(list_weights[i]);
         end
         unsplit_sum  = total;
         unsplit_pool = $signed(it.pool_amount);
         // Weighted mode with nothing to weigh by falls back to an even split. Strict mode
         // (and the reserved code) leaves every entry unchanged instead.
         even_split = (it.mode == MODE_EVEN) || (it.mode == MODE_WEIGHTED && total == 0);
         for (int i = 0; i < list_len; i++) begin
            wt      = longint'(list_weights[i]);
            portion = 0;
            if (even_split) begin
               portion = unsplit_pool / longint'(list_len - i);
               unsplit_pool -= portion;
            end else if (unsplit_sum != 0) begin
               // Once the weight sum runs out, the remaining zero-weight entries pass unchanged
               // and the leftover pool is simply kept.
               portion = (wt * unsplit_pool) / unsplit_sum;
               unsplit_sum  -= wt;
               unsplit_pool -= portion;
            end
            res.new_value   = VALUE_W'(wt + portion);
            res.entry_index = ENTRY_W'(i);
            res.last_result = (i + 1 == list_len);
            pending_results.push_back(res);
         end
         list_len = 0;
      end
   endtask

   task automatic add_item(input logic [WEIGHT_W-1:0] w, input logic [POOL_W-1:0] pool,
                           input logic [MODE_W-1:0] mode, input logic last,
                           input logic typed, input logic [VALUE_W-1:0] value);
      load_item_type it;
      it = '{w, pool, mode, last, typed, value};
      load_items.push_back(it);
   endtask

   // Pool amounts lean on the extremes and on small values that divide unevenly.
   function automatic logic [POOL_W-1:0] pick_pool();
      case ($urandom_range(0, 5))
         0:       return POOL_MAX;
         1:       return POOL_MIN;
         2:       return POOL_W'(int'($urandom_range(0, 100)) - 50);
         default: return POOL_W'($urandom);
      endcase
   endfunction

   // Sender: builds the stimulus, releases reset and then offers the items in bursts of
   // random length separated by random gaps. The model sees an item at the edge that takes it.
   initial begin
      int unsigned   burst_left;
      int unsigned   gap;
      int unsigned   random_count;
      int unsigned   list_size;
      int unsigned   list_no;
      logic          zero_list;
      logic [WEIGHT_W-1:0] w;
      load_item_type it;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_weight      <= '0;
      req_pool_amount <= '0;
      req_mode        <= MODE_EVEN;
      req_is_last     <= 1'b0;

      // One-entry lists whose single result can be read straight off the definition.
      add_item(16'd0,      31'sd0,      MODE_EVEN,     1'b1, 1'b1, 32'sd0);
      add_item(16'hFFFF,   POOL_MAX,    MODE_EVEN,     1'b1, 1'b1, 32'sd1073807358);
      add_item(16'hFFFF,   POOL_MIN,    MODE_WEIGHTED, 1'b1, 1'b1, -32'sd1073676289);
      add_item(16'd0,      POOL_MIN,    MODE_EVEN,     1'b1, 1'b1, -32'sd1073741824);
      // Zero total: weighted falls back to even, strict leaves the entry alone.
      add_item(16'd0,      31'sd12345,  MODE_WEIGHTED, 1'b1, 1'b1, 32'sd12345);
      add_item(16'd0,      31'sd12345,  MODE_STRICT,   1'b1, 1'b1, 32'sd0);
      // The reserved mode code behaves as weighted strict.
      add_item(16'd7,      -31'sd100,   MODE_RESERVED, 1'b1, 1'b1, -32'sd93);
      // Short lists left to the model: weighted split with truncation.
      add_item(16'd1,      POOL_MIN,    MODE_STRICT,   1'b0, 1'b0, '0);
      add_item(16'd2,      31'sd3,      MODE_RESERVED, 1'b0, 1'b0, '0);
      add_item(16'd3,      31'sd100,    MODE_WEIGHTED, 1'b1, 1'b0, '0);
      // Even split of a negative pool, rounding toward zero.
      add_item(16'd9,      31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'd0,      31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'hFFFF,   -31'sd10,    MODE_EVEN,     1'b1, 1'b0, '0);
      // Weight sum runs out after the first entry; the zero-weight tail passes unchanged.
      add_item(16'd5,      31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'd0,      31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'd0,      31'sd7,      MODE_WEIGHTED, 1'b1, 1'b0, '0);
      // All-zero list in strict mode, then heavy weights in strict mode at full pool.
      add_item(16'd0,      31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'd0,      31'sd500,    MODE_STRICT,   1'b1, 1'b0, '0);
      add_item(16'hFFFF,   31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'hFFFF,   31'sd0,      MODE_EVEN,     1'b0, 1'b0, '0);
      add_item(16'd1,      POOL_MAX,    MODE_STRICT,   1'b1, 1'b0, '0);

      // Random lists: mostly short, some medium, and now and then one that overflows the
      // store so that weights, the last one included, are dropped.
      random_count = load_items.size();
      list_no      = 0;
      while (random_count < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0:       list_size = $urandom_range(60, 70);
            1, 2:    list_size = $urandom_range(7, 20);
            default: list_size = $urandom_range(1, 6);
         endcase
         if (list_no == 2) begin
            list_size = $urandom_range(MAX_ENTRIES_DEF + 1, MAX_ENTRIES_DEF + 6);
         end
         zero_list = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < list_size; k++) begin
            case ($urandom_range(0, 7))
               0:       w = '0;
               1:       w = '1;
               2:       w = WEIGHT_W'($urandom_range(0, 15));
               default: w = WEIGHT_W'($urandom);
            endcase
            if (zero_list) begin
               w = '0;
            end
            // Pool and mode only count on the last item; elsewhere they are noise.
            add_item(w, pick_pool(), MODE_W'($urandom_range(0, 3)), k + 1 == list_size,
                     1'b0, '0);
         end
         random_count += list_size;
         list_no++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      foreach (load_items[n]) begin
         it = load_items[n];
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         start           <= 1'b1;
         req_weight      <= it.weight;
         req_pool_amount <= it.pool_amount;
         req_mode        <= it.mode;
         req_is_last     <= it.is_last;
         // busy read here is its value before this edge, which is what decides acceptance.
         do @(posedge clock); while (busy);
         split_pool(it);
         if (it.typed) begin
            // The hand-written result replaces the modelled one for this one-entry list.
            pending_results[pending_results.size() - 1] = '{it.typed_value, '0, 1'b1};
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Result checker: a strobed entry is taken at the edge that ends its cycle and compared
   // with the oldest expectation, field by field.
   always @(posedge clock) begin : check_entries
      entry_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected entry: entry_index %0d new_value %0d", rsp_entry_index,
                   rsp_new_value);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_new_value !== $signed(want.new_value)) begin
               $error("new_value: expected %0d, actual %0d", $signed(want.new_value),
                      rsp_new_value);
               mismatch_count++;
            end
            if (rsp_entry_index !== want.entry_index) begin
               $error("entry_index: expected %0d, actual %0d", want.entry_index,
                      rsp_entry_index);
               mismatch_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result: expected %0b, actual %0b", want.last_result,
                      rsp_last_result);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any accepted item or result restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> proportional_pool_distributor.f
rtl/core/ppd_pkg.sv
rtl/core/ppd_ram.sv
rtl/core/ppd_divider.sv
rtl/core/proportional_pool_distributor.sv
rtl/core/ppd_checker.sv
bench/tb_proportional_pool_distributor.sv
